FILE: design/amsdu_pkg.sv
package amsdu_pkg;

  // frame layout
  localparam int ADDR_BYTES    = 12;
  localparam int ETH_HDR_BYTES = 14;
  localparam int AGG_HDR_BYTES = 6;
  localparam int AGG_COUNT_POS = 2;
  localparam int MIN_SUB_LEN   = 2;

  // default length table depth
  localparam int LEN_TBL_DEPTH = 256;

  // length entry width
  localparam int LEN_W = 16;

  // where the parser is inside the aggregate
  typedef enum logic [1:0] {
    PH_ETH,
    PH_AGG,
    PH_LEN,
    PH_PAY
  } phase_t;

  // sequencing around the byte stream
  typedef enum logic [1:0] {
    CTL_RUN,
    CTL_ADDR,
    CTL_LDREQ,
    CTL_LDWAIT
  } ctl_t;

endpackage

FILE: design/amsdu_len_table.sv
module amsdu_len_table #(
  parameter int DEPTH = amsdu_pkg::LEN_TBL_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [amsdu_pkg::LEN_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [amsdu_pkg::LEN_W-1:0] rd_data
);

  logic [amsdu_pkg::LEN_W-1:0] mem [DEPTH];
  logic [amsdu_pkg::LEN_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/amsdu_deaggregator_unit.sv
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// in       | in_valid, in_ready, in_byte,            | input
//          | in_frame_last                           |
// out      | out_valid, out_ready, out_byte,         | output
//          | out_sub_first, out_sub_last,            |
//          | out_sub_index, out_agg_done,            |
//          | out_frame_error                         |
//
// header, length and payload bytes are taken one per cycle, except during
// address replay, length loads or a stalled output; the first payload byte
// of a subframe follows the 12 address bytes from the address register file
// each subframe length comes from the length table (one write and one read port,
// registered read): entering payload after a length table and each boundary into a
// non-last subframe pass through the read request and capture states
// rst_n is synchronous; it clears control state, the tables are not cleared
// a stalled output holds its result and blocks input until taken
module amsdu_deaggregator_unit #(
  parameter int LENGTH_TABLE_DEPTH = amsdu_pkg::LEN_TBL_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_sub_first,
  output logic       out_sub_last,
  output logic [7:0] out_sub_index,
  output logic       out_agg_done,
  output logic       out_frame_error
);

  localparam int TBL_AW = (LENGTH_TABLE_DEPTH > 1) ? $clog2(LENGTH_TABLE_DEPTH) : 1;
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(LENGTH_TABLE_DEPTH - 1);
  localparam int LW = amsdu_pkg::LEN_W;

  // control state
  amsdu_pkg::ctl_t   ctl_r, ctl_nxt;
  amsdu_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]        hbc_r, hbc_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        cur_r, cur_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic              seen_r, seen_nxt;
  logic              drop_r, drop_nxt;
  logic              fresh_r, fresh_nxt;
  logic [TBL_AW-1:0] wptr_r, wptr_nxt;
  logic [TBL_AW-1:0] rptr_r, rptr_nxt;
  logic [3:0]        addr_k_r, addr_k_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] addr_store [amsdu_pkg::ADDR_BYTES];
  logic [7:0] hold_byte_r, hold_byte_nxt;
  logic       hold_last_r, hold_last_nxt;
  logic [7:0] hold_idx_r, hold_idx_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_first_r, out_first_nxt;
  logic       out_last_r, out_last_nxt;
  logic [7:0] out_idx_r, out_idx_nxt;
  logic       out_done_r, out_done_nxt;
  logic       out_err_r, out_err_nxt;

  // helpers
  logic          out_free;
  logic          in_acc;
  logic          out_ld;
  logic          addr_we;
  logic [3:0]    addr_wa;
  logic          tbl_we;
  logic [LW-1:0] tbl_wdata;
  logic          tbl_re;
  logic [LW-1:0] tbl_rdata;
  logic [9:0]    hbc_inc;
  logic [8:0]    len_total;
  logic          nonlast;
  logic          raise_err;
  logic          new_frame;
  logic [LW-1:0] len_word;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (ctl_r == amsdu_pkg::CTL_RUN) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign hbc_inc   = hbc_r + 10'd1;
  assign len_total = {cnt_r - 8'd1, 1'b0};
  assign nonlast   = ({1'b0, cur_r} + 9'd1) < {1'b0, cnt_r};
  assign len_word  = {hi_r, in_byte};
  assign tbl_wdata = len_word;
  assign tbl_re    = (ctl_r == amsdu_pkg::CTL_LDREQ);

  // subframe length table
  amsdu_len_table #(
    .DEPTH (LENGTH_TABLE_DEPTH)
  ) u_len_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (wptr_r),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_re),
    .rd_addr (rptr_r),
    .rd_data (tbl_rdata)
  );

  // parser and output sequencing
  always_comb begin
    ctl_nxt       = ctl_r;
    phase_nxt     = phase_r;
    hbc_nxt       = hbc_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    seen_nxt      = seen_r;
    drop_nxt      = drop_r;
    fresh_nxt     = fresh_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    addr_k_nxt    = addr_k_r;
    hi_nxt        = hi_r;
    hold_byte_nxt = hold_byte_r;
    hold_last_nxt = hold_last_r;
    hold_idx_nxt  = hold_idx_r;
    out_ld        = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    out_idx_nxt   = out_idx_r;
    out_done_nxt  = out_done_r;
    out_err_nxt   = out_err_r;
    addr_we       = 1'b0;
    addr_wa       = hbc_r[3:0];
    tbl_we        = 1'b0;
    raise_err     = 1'b0;
    new_frame     = 1'b0;

    unique case (ctl_r)
      amsdu_pkg::CTL_RUN: begin
        if (in_acc) begin
          if (drop_r) begin
            // swallow the rest of a bad aggregate
            new_frame = in_frame_last;
          end else begin
            unique case (phase_r)
              amsdu_pkg::PH_ETH: begin
                if (in_frame_last) begin
                  raise_err = 1'b1;
                end else begin
                  addr_we = hbc_r < 10'(amsdu_pkg::ADDR_BYTES);
                  hbc_nxt = hbc_inc;
                  if (hbc_r == 10'(amsdu_pkg::ETH_HDR_BYTES - 1)) begin
                    phase_nxt = amsdu_pkg::PH_AGG;
                    hbc_nxt   = '0;
                  end
                end
              end
              amsdu_pkg::PH_AGG: begin
                if (in_frame_last) begin
                  raise_err = 1'b1;
                end else if (hbc_r == 10'(amsdu_pkg::AGG_COUNT_POS) && in_byte == 8'd0) begin
                  raise_err = 1'b1;
                end else begin
                  if (hbc_r == 10'(amsdu_pkg::AGG_COUNT_POS)) begin
                    cnt_nxt = in_byte;
                  end
                  hbc_nxt = hbc_inc;
                  if (hbc_r == 10'(amsdu_pkg::AGG_HDR_BYTES - 1)) begin
                    hbc_nxt = '0;
                    if (cnt_r == 8'd1) begin
                      // single subframe takes the whole payload
                      phase_nxt = amsdu_pkg::PH_PAY;
                      cur_nxt   = '0;
                      seen_nxt  = 1'b0;
                      left_nxt  = '0;
                    end else begin
                      phase_nxt = amsdu_pkg::PH_LEN;
                      wptr_nxt  = '0;
                    end
                  end
                end
              end
              amsdu_pkg::PH_LEN: begin
                if (in_frame_last) begin
                  raise_err = 1'b1;
                end else if (!hbc_r[0]) begin
                  hi_nxt  = in_byte;
                  hbc_nxt = hbc_inc;
                end else if (len_word < LW'(amsdu_pkg::MIN_SUB_LEN)) begin
                  raise_err = 1'b1;
                end else begin
                  tbl_we   = 1'b1;
                  wptr_nxt = (wptr_r == TBL_LAST) ? '0 : wptr_r + 1'b1;
                  hbc_nxt  = hbc_inc;
                  if (hbc_inc == {1'b0, len_total}) begin
                    // table complete, fetch the first length
                    hbc_nxt   = '0;
                    phase_nxt = amsdu_pkg::PH_PAY;
                    cur_nxt   = '0;
                    seen_nxt  = 1'b0;
                    rptr_nxt  = '0;
                    ctl_nxt   = amsdu_pkg::CTL_LDREQ;
                  end
                end
              end
              amsdu_pkg::PH_PAY: begin
                if (nonlast) begin
                  if (in_frame_last) begin
                    raise_err = 1'b1;
                  end else begin
                    left_nxt  = left_r - 1'b1;
                    fresh_nxt = 1'b0;
                    if (left_r == LW'(1)) begin
                      // subframe boundary
                      cur_nxt  = cur_r + 8'd1;
                      seen_nxt = 1'b0;
                      if (({1'b0, cur_r} + 9'd2) < {1'b0, cnt_r}) begin
                        rptr_nxt = (rptr_r == TBL_LAST) ? '0 : rptr_r + 1'b1;
                        ctl_nxt  = amsdu_pkg::CTL_LDREQ;
                      end
                    end
                    out_ld = 1'b1;
                    if (fresh_r) begin
                      hold_byte_nxt = in_byte;
                      hold_last_nxt = 1'b0;
                      hold_idx_nxt  = cur_r;
                      addr_k_nxt    = 4'd1;
                      ctl_nxt       = amsdu_pkg::CTL_ADDR;
                      out_byte_nxt  = addr_store[0];
                      out_first_nxt = 1'b1;
                      out_last_nxt  = 1'b0;
                    end else begin
                      out_byte_nxt  = in_byte;
                      out_first_nxt = 1'b0;
                      out_last_nxt  = (left_r == LW'(1));
                    end
                    out_idx_nxt  = cur_r;
                    out_done_nxt = 1'b0;
                    out_err_nxt  = 1'b0;
                  end
                end else if (!seen_r && in_frame_last) begin
                  raise_err = 1'b1;
                end else begin
                  // last subframe runs to the frame end
                  seen_nxt     = 1'b1;
                  new_frame    = in_frame_last;
                  out_ld       = 1'b1;
                  out_idx_nxt  = cur_r;
                  out_err_nxt  = 1'b0;
                  if (!seen_r) begin
                    hold_byte_nxt = in_byte;
                    hold_last_nxt = in_frame_last;
                    hold_idx_nxt  = cur_r;
                    addr_k_nxt    = 4'd1;
                    ctl_nxt       = amsdu_pkg::CTL_ADDR;
                    out_byte_nxt  = addr_store[0];
                    out_first_nxt = 1'b1;
                    out_last_nxt  = 1'b0;
                    out_done_nxt  = 1'b0;
                  end else begin
                    out_byte_nxt  = in_byte;
                    out_first_nxt = 1'b0;
                    out_last_nxt  = in_frame_last;
                    out_done_nxt  = in_frame_last;
                  end
                end
              end
              default: begin
                phase_nxt = amsdu_pkg::PH_ETH;
              end
            endcase

            // single error transaction
            if (raise_err) begin
              out_ld        = 1'b1;
              out_byte_nxt  = '0;
              out_first_nxt = 1'b0;
              out_last_nxt  = 1'b0;
              out_idx_nxt   = '0;
              out_done_nxt  = 1'b1;
              out_err_nxt   = 1'b1;
              ctl_nxt       = amsdu_pkg::CTL_RUN;
              if (in_frame_last) begin
                new_frame = 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
          end
        end
      end
      amsdu_pkg::CTL_ADDR: begin
        // replay stored addresses, then the held payload byte
        if (out_free) begin
          out_ld        = 1'b1;
          out_first_nxt = 1'b0;
          out_idx_nxt   = hold_idx_r;
          out_err_nxt   = 1'b0;
          if (addr_k_r < 4'(amsdu_pkg::ADDR_BYTES)) begin
            out_byte_nxt = addr_store[addr_k_r];
            out_last_nxt = 1'b0;
            out_done_nxt = 1'b0;
            addr_k_nxt   = addr_k_r + 4'd1;
          end else begin
            out_byte_nxt = hold_byte_r;
            out_last_nxt = hold_last_r;
            out_done_nxt = hold_last_r;
            ctl_nxt      = amsdu_pkg::CTL_RUN;
          end
        end
      end
      amsdu_pkg::CTL_LDREQ: begin
        ctl_nxt = amsdu_pkg::CTL_LDWAIT;
      end
      amsdu_pkg::CTL_LDWAIT: begin
        left_nxt  = tbl_rdata;
        fresh_nxt = 1'b1;
        ctl_nxt   = amsdu_pkg::CTL_RUN;
      end
      default: begin
        ctl_nxt = amsdu_pkg::CTL_RUN;
      end
    endcase

    // restart parsing for the next aggregate
    if (new_frame) begin
      phase_nxt = amsdu_pkg::PH_ETH;
      hbc_nxt   = '0;
      cnt_nxt   = '0;
      cur_nxt   = '0;
      left_nxt  = '0;
      seen_nxt  = 1'b0;
      drop_nxt  = 1'b0;
      fresh_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= amsdu_pkg::CTL_RUN;
      phase_r     <= amsdu_pkg::PH_ETH;
      hbc_r       <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      left_r      <= '0;
      seen_r      <= 1'b0;
      drop_r      <= 1'b0;
      fresh_r     <= 1'b0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      addr_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      hbc_r       <= hbc_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      left_r      <= left_nxt;
      seen_r      <= seen_nxt;
      drop_r      <= drop_nxt;
      fresh_r     <= fresh_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      addr_k_r    <= addr_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hi_r        <= hi_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_last_r <= hold_last_nxt;
    hold_idx_r  <= hold_idx_nxt;
    out_byte_r  <= out_byte_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    out_idx_r   <= out_idx_nxt;
    out_done_r  <= out_done_nxt;
    out_err_r   <= out_err_nxt;
  end

  // address store
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_store[addr_wa] <= in_byte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_sub_first   = out_first_r;
  assign out_sub_last    = out_last_r;
  assign out_sub_index   = out_idx_r;
  assign out_agg_done    = out_done_r;
  assign out_frame_error = out_err_r;

`ifndef SYNTHESIS
  // error transactions always close the aggregate
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_done_r && !out_first_r && !out_last_r)
    else $error("error transaction without agg_done");

  // address replay index stays inside the store plus the held byte
  a_addr_k: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == amsdu_pkg::CTL_ADDR |-> addr_k_r != 4'd0 &&
      addr_k_r <= 4'(amsdu_pkg::ADDR_BYTES))
    else $error("address replay index out of range");

  // a table read request is always followed in the next cycle by the capture state
  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == amsdu_pkg::CTL_LDREQ |=> ctl_r == amsdu_pkg::CTL_LDWAIT)
    else $error("length table read not followed by capture");

  // a non-last subframe never runs with an empty length
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == amsdu_pkg::CTL_RUN && phase_r == amsdu_pkg::PH_PAY && !drop_r &&
      nonlast |-> left_r != '0)
    else $error("non-last subframe with zero bytes left");
`endif

endmodule
